// ----- hw/rtl/bitmap_id_allocator_top_macros.svh -----
// ----------------------------------------------------------------------------
// Bitmap id allocator assertion macros
// Concurrent assertion helpers for the allocator; they compile to nothing in
// synthesis.
// ----------------------------------------------------------------------------
`ifndef BITMAP_ID_ALLOCATOR_TOP_MACROS_SVH
`define BITMAP_ID_ALLOCATOR_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Assertion on an explicit clock and active-low reset.
`define BIA_ASSERT_CLK(lbl, clk_sig, rst_sig, prop, msg) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rst_sig) prop) else $error(msg);
// Assertion on the block clock and reset.
`define BIA_ASSERT(lbl, prop, msg) \
	`BIA_ASSERT_CLK(lbl, clk, arst_n, prop, msg)
`else
`define BIA_ASSERT_CLK(lbl, clk_sig, rst_sig, prop, msg)
`define BIA_ASSERT(lbl, prop, msg)
`endif

`endif

// ----- hw/rtl/bia_pkg.sv -----
// ----------------------------------------------------------------------------
// Bitmap id allocator package
// Beat types, status codes and bit unit types shared across the allocator.
// ----------------------------------------------------------------------------
package bia_pkg;

	localparam int ID_W = 11;

	// Opcodes of a command beat.
	localparam logic OPC_ALLOC = 1'b0;
	localparam logic OPC_FREE  = 1'b1;

	// Result status codes.
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_BAD  = 2'd2;

	// A freshly grown byte has every id free.
	localparam logic [7:0] ALL_FREE = 8'hff;

	typedef struct packed {
		logic            opcode;
		logic [ID_W-1:0] freed_id;
	} cmd_t;

	typedef struct packed {
		logic [ID_W-1:0] given_id;
		logic [1:0]      status;
	} res_t;

	// Operations of the shared bit unit.
	typedef enum logic {
		BU_CLR_LOW,
		BU_SET_IDX
	} bu_op_t;

	typedef struct packed {
		bu_op_t     op;
		logic [7:0] data;
		logic [2:0] idx;
	} bu_req_t;

	typedef struct packed {
		logic [7:0] data;
		logic [2:0] low_idx;
		logic       any;
	} bu_rsp_t;

endpackage

// ----- hw/rtl/bia_map_ram.sv -----
// ----------------------------------------------------------------------------
// Bitmap id allocator map RAM
// Free-bit map storage: one write port and one read port with registered data.
// ----------------------------------------------------------------------------
module bia_map_ram #(
	parameter int DEPTH = 128,
	parameter int AW    = 7
) (
	input  logic          clk,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [7:0]    rd_data,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [7:0]    wr_data
);

	logic [7:0] mem_q [DEPTH];
	logic [7:0] rd_data_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Read port; the data holds until the next read.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- hw/rtl/bia_bit_unit.sv -----
// ----------------------------------------------------------------------------
// Bitmap id allocator bit unit
// Shared byte unit: finds and clears the lowest free bit, or sets a given bit.
// ----------------------------------------------------------------------------
module bia_bit_unit
	import bia_pkg::*;
(
	input  bu_req_t req,
	output bu_rsp_t rsp
);

	logic [2:0] low;
	logic [2:0] sel;

	// Lowest set bit; an empty byte reports bit seven.
	always_comb begin
		low = 3'd7;
		for (int i = 7; i >= 0; i--) begin
			if (req.data[i]) begin
				low = 3'(i);
			end
		end
	end

	// Clear the lowest free bit or set the requested one.
	always_comb begin
		case (req.op)
			BU_CLR_LOW: begin
				sel      = low;
				rsp.data = req.data & ~(8'd1 << sel);
			end
			BU_SET_IDX: begin
				sel      = req.idx;
				rsp.data = req.data | (8'd1 << sel);
			end
			default: begin
				sel      = low;
				rsp.data = req.data;
			end
		endcase
		rsp.low_idx = low;
		rsp.any     = |req.data;
	end

endmodule

// ----- hw/rtl/bitmap_id_allocator_top.sv -----
// ----------------------------------------------------------------------------
// Bitmap id allocator
// Hands out and takes back one-based ids from a free-bit map held in a RAM,
// under a small sequencer that drives one shared bit unit.
// ----------------------------------------------------------------------------
//  Channel   Ports                  Beat taken when
//  command   start, busy, cmd       start high and busy low at a rising edge
//  result    done, result           done high, one cycle, at the edge ending it
//
//  A free goes through a check state and a write state to the result strobe;
//  a bad id is reported from the check state. An allocate reads the RAM one
//  byte a cycle down from the top of the map and stops at the first free bit.
//  A failed scan over all active bytes goes to a growth check that either reports
//  full, or grows the map by writing one new byte a cycle, GROW_BYTES bytes at most.
//  Reset needs no clearing pass: only bytes below the active count are read.
//  The receiver cannot stall; busy stays high until the result strobe.
// ----------------------------------------------------------------------------
`include "bitmap_id_allocator_top_macros.svh"

module bitmap_id_allocator_top
	import bia_pkg::*;
#(
	parameter int MAP_BYTES  = 128,
	parameter int GROW_BYTES = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  cmd_t cmd,
	output logic busy,
	output logic done,
	output res_t result
);

	localparam int AW  = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
	localparam int ABW = $clog2(MAP_BYTES + 1);
	localparam int GBW = $clog2(GROW_BYTES + 1);
	localparam int GW  = ((ABW > GBW) ? ABW : GBW) + 1;
	localparam int CW  = (ABW + 3 > ID_W) ? ABW + 3 : ID_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_FREE_CHK,
		S_FREE_WR,
		S_GROW_CHK,
		S_GROW_FILL
	} state_t;

	state_t          state_q;
	logic [ABW-1:0]  active_q;
	logic [ID_W-1:0] id_q;
	logic [AW-1:0]   rd_k_q;
	logic            more_q;
	logic            chk_v_s1;
	logic [AW-1:0]   chk_k_s1;
	logic [ABW-1:0]  new_top_q;
	logic [AW-1:0]   wr_k_q;
	logic [AW-1:0]   last_k_q;
	logic            done_q;
	res_t            result_q;

	logic            rd_en;
	logic [AW-1:0]   rd_addr;
	logic [7:0]      rd_data;
	logic            wr_en;
	logic [AW-1:0]   wr_addr;
	logic [7:0]      wr_data;
	bu_req_t         bu_req;
	bu_rsp_t         bu_rsp;

	logic [ID_W-1:0] id0;
	logic [AW-1:0]   free_k;
	logic            bad_id;
	logic            hit;
	logic [GW-1:0]   grow_sum;
	logic [ABW-1:0]  new_top;
	logic [CW-1:0]   scan_id;
	logic [CW-1:0]   grow_id;

	// Map storage.
	bia_map_ram #(
		.DEPTH (MAP_BYTES),
		.AW    (AW)
	) u_map (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	// Shared bit unit.
	bia_bit_unit u_bit (
		.req (bu_req),
		.rsp (bu_rsp)
	);

	// Id decode and range check for a free.
	assign id0    = id_q - ID_W'(1);
	assign free_k = AW'(id0[ID_W-1:3]);
	assign bad_id = (id_q == '0) || (CW'(id_q) > CW'({active_q, 3'b000}));

	// Scan result and growth bounds.
	assign hit      = (state_q == S_SCAN) && chk_v_s1 && bu_rsp.any;
	assign grow_sum = GW'(active_q) + GW'(GROW_BYTES);
	assign new_top  = (grow_sum > GW'(MAP_BYTES)) ? ABW'(MAP_BYTES) : ABW'(grow_sum);
	assign scan_id  = CW'({chk_k_s1, bu_rsp.low_idx}) + CW'(1);
	assign grow_id  = CW'({last_k_q, 3'b000}) + CW'(1);

	// Bit unit operand selection.
	always_comb begin
		case (state_q)
			S_FREE_WR: begin
				bu_req.op   = BU_SET_IDX;
				bu_req.data = rd_data;
				bu_req.idx  = id0[2:0];
			end
			S_GROW_FILL: begin
				bu_req.op   = BU_CLR_LOW;
				bu_req.data = ALL_FREE;
				bu_req.idx  = 3'd0;
			end
			default: begin
				bu_req.op   = BU_CLR_LOW;
				bu_req.data = rd_data;
				bu_req.idx  = 3'd0;
			end
		endcase
	end

	// RAM port control.
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = rd_k_q;
		wr_en   = 1'b0;
		wr_addr = chk_k_s1;
		wr_data = bu_rsp.data;
		case (state_q)
			S_SCAN: begin
				rd_en = more_q;
				wr_en = hit;
			end
			S_FREE_CHK: begin
				rd_en   = !bad_id;
				rd_addr = free_k;
			end
			S_FREE_WR: begin
				wr_en   = 1'b1;
				wr_addr = free_k;
			end
			S_GROW_FILL: begin
				wr_en   = 1'b1;
				wr_addr = wr_k_q;
				wr_data = (wr_k_q == last_k_q) ? bu_rsp.data : ALL_FREE;
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	// Sequencer with registered result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			active_q  <= '0;
			id_q      <= '0;
			rd_k_q    <= '0;
			more_q    <= 1'b0;
			chk_v_s1  <= 1'b0;
			chk_k_s1  <= '0;
			new_top_q <= '0;
			wr_k_q    <= '0;
			last_k_q  <= '0;
			done_q    <= 1'b0;
			result_q  <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						id_q <= cmd.freed_id;
						if (cmd.opcode == OPC_FREE) begin
							state_q <= S_FREE_CHK;
						end else if (active_q == '0) begin
							state_q <= S_GROW_CHK;
						end else begin
							rd_k_q   <= AW'(active_q - ABW'(1));
							more_q   <= 1'b1;
							chk_v_s1 <= 1'b0;
							state_q  <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (hit) begin
						result_q.given_id <= scan_id[ID_W-1:0];
						result_q.status   <= ST_OK;
						done_q            <= 1'b1;
						chk_v_s1          <= 1'b0;
						state_q           <= S_IDLE;
					end else if (chk_v_s1 && (chk_k_s1 == '0)) begin
						chk_v_s1 <= 1'b0;
						state_q  <= S_GROW_CHK;
					end else begin
						chk_v_s1 <= more_q;
						chk_k_s1 <= rd_k_q;
						if (more_q) begin
							if (rd_k_q == '0) begin
								more_q <= 1'b0;
							end else begin
								rd_k_q <= rd_k_q - AW'(1);
							end
						end
					end
				end
				S_FREE_CHK: begin
					if (bad_id) begin
						result_q.given_id <= '0;
						result_q.status   <= ST_BAD;
						done_q            <= 1'b1;
						state_q           <= S_IDLE;
					end else begin
						state_q <= S_FREE_WR;
					end
				end
				S_FREE_WR: begin
					result_q.given_id <= '0;
					result_q.status   <= ST_OK;
					done_q            <= 1'b1;
					state_q           <= S_IDLE;
				end
				S_GROW_CHK: begin
					if (active_q == ABW'(MAP_BYTES)) begin
						result_q.given_id <= '0;
						result_q.status   <= ST_FULL;
						done_q            <= 1'b1;
						state_q           <= S_IDLE;
					end else begin
						new_top_q <= new_top;
						wr_k_q    <= AW'(active_q);
						last_k_q  <= AW'(new_top - ABW'(1));
						state_q   <= S_GROW_FILL;
					end
				end
				S_GROW_FILL: begin
					if (wr_k_q == last_k_q) begin
						active_q          <= new_top_q;
						result_q.given_id <= grow_id[ID_W-1:0];
						result_q.status   <= ST_OK;
						done_q            <= 1'b1;
						state_q           <= S_IDLE;
					end else begin
						wr_k_q <= wr_k_q + AW'(1);
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = result_q;

	// Checks on the sequencer.
	`BIA_ASSERT(a_accept_busy, (start && !busy) |=> busy, "accepted command did not raise busy")
	`BIA_ASSERT(a_done_after_busy, done |-> $past(busy), "result strobe without work in flight")
	`BIA_ASSERT(a_fail_no_id, (done && (result.status != ST_OK)) |-> (result.given_id == '0), "id given on a failed request")
	`BIA_ASSERT_CLK(a_status_code, clk, arst_n, done |-> ((result.status == ST_OK) || (result.status == ST_FULL) || (result.status == ST_BAD)), "undefined status code")

endmodule

// ----- dv/tb_bitmap_id_allocator_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap id allocator testbench
// Drives allocate and free commands through the start/busy handshake and
// checks every result strobe against an in-bench model of the free-bit map.
// The run covers bad ids, double frees, growth and a completely full map.
// ----------------------------------------------------------------------------
module tb_bitmap_id_allocator_top
	import bia_pkg::*;
;

	localparam int MAP_BYTES  = 128;
	localparam int GROW_BYTES = 32;
	localparam int DRAIN_CYCLES = 20000;

	logic clk;
	logic arst_n;
	logic start;
	cmd_t cmd;
	logic busy;
	logic done;
	res_t result;

	// Model of the free-bit map: a set bit marks a free id.
	logic [7:0]  id_map [MAP_BYTES];
	int unsigned map_active_bytes;

	// Results still owed by the block, oldest first.
	res_t pending_results [$];
	int   error_count;
	int   full_count;

	bitmap_id_allocator_top #(
		.MAP_BYTES  (MAP_BYTES),
		.GROW_BYTES (GROW_BYTES)
	) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done),
		.result (result)
	);

	// Free-running clock with a 10 ns period.
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Applies one command to the map model and returns the result it owes.
	function automatic res_t apply_command(input cmd_t c);
		res_t        r;
		int unsigned k;
		int unsigned b;
		int unsigned new_top;
		int unsigned id0;
		r.given_id = '0;
		r.status   = ST_OK;
		if (c.opcode == OPC_ALLOC) begin
			// Scan the active bytes from the top down for a free bit.
			for (int i = int'(map_active_bytes) - 1; i >= 0; i--) begin
				if (id_map[i] != 8'h00) begin
					b = 0;
					while (b < 7 && !id_map[i][b])
						b++;
					id_map[i][b] = 1'b0;
					r.given_id = ID_W'(i * 8 + b + 1);
					return r;
				end
			end
			if (map_active_bytes >= MAP_BYTES) begin
				r.status = ST_FULL;
				return r;
			end
			// Nothing free: grow the map and hand out bit 0 of the new top byte.
			new_top = map_active_bytes + GROW_BYTES;
			if (new_top > MAP_BYTES)
				new_top = MAP_BYTES;
			for (k = map_active_bytes; k < new_top; k++)
				id_map[k] = ALL_FREE;
			map_active_bytes = new_top;
			id_map[new_top - 1][0] = 1'b0;
			r.given_id = ID_W'((new_top - 1) * 8 + 1);
		end else begin
			if (c.freed_id == 0 || c.freed_id > map_active_bytes * 8) begin
				r.status = ST_BAD;
				return r;
			end
			id0 = c.freed_id - 1;
			id_map[id0 >> 3][id0 & 7] = 1'b1;
		end
		return r;
	endfunction

	// Presents one command and waits for the edge that accepts it. The start
	// line is left high so that a following command can go out back to back.
	task automatic send_command(input cmd_t c);
		start <= 1'b1;
		cmd   <= c;
		do
			@(posedge clk);
		while (busy);
		pending_results.push_back(apply_command(c));
		if (pending_results[$].status == ST_FULL)
			full_count++;
	endtask

	// Lowers start for a random stretch with the given chance per beat.
	task automatic maybe_pause(input int idle_pct);
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 40)) @(posedge clk);
		end
	endtask

	// One random command: an allocate with the given chance, else a free that is
	// mostly well-formed inside the active map, with some random ids that are usually out of range.
	task automatic send_random_command(input int alloc_pct);
		cmd_t c;
		c.freed_id = ID_W'($urandom);
		if ($urandom_range(99) < alloc_pct) begin
			c.opcode = OPC_ALLOC;
		end else begin
			c.opcode = OPC_FREE;
			if (map_active_bytes > 0 && $urandom_range(99) < 85)
				c.freed_id = ID_W'($urandom_range(1, map_active_bytes * 8));
		end
		send_command(c);
	endtask

	// Corner cases: empty map, first growth, edges of the active range,
	// freeing a free id and ids with every bit set.
	task automatic test_directed_corners();
		send_command('{OPC_FREE,  11'd0});
		send_command('{OPC_FREE,  11'd1});
		send_command('{OPC_ALLOC, 11'd2047});
		send_command('{OPC_ALLOC, 11'd0});
		send_command('{OPC_FREE,  11'd249});
		send_command('{OPC_ALLOC, 11'd1024});
		send_command('{OPC_FREE,  11'd256});
		send_command('{OPC_FREE,  11'd257});
		send_command('{OPC_FREE,  11'd2047});
		send_command('{OPC_FREE,  11'd1024});
		send_command('{OPC_FREE,  11'd1});
		send_command('{OPC_FREE,  11'd1});
		send_command('{OPC_FREE,  11'd0});
		send_command('{OPC_ALLOC, 11'd1});
	endtask

	// Mixed traffic with back-to-back beats unless idle_pct pauses them.
	task automatic test_mixed_traffic(input int count, input int idle_pct);
		repeat (count) begin
			maybe_pause(idle_pct);
			send_random_command(60);
		end
	endtask

	// Allocation-heavy traffic that grows the map to capacity and keeps
	// asking until the full status has been seen a few times.
	task automatic test_fill_to_capacity(input int idle_pct);
		int guard;
		guard = 0;
		while (full_count < 3 && guard < 2500) begin
			maybe_pause(idle_pct);
			send_random_command(92);
			guard++;
		end
	endtask

	// Free-heavy traffic on a full map, so that freed ids get reused.
	task automatic test_release_and_reuse(input int count, input int idle_pct);
		repeat (count) begin
			maybe_pause(idle_pct);
			send_random_command(35);
		end
	endtask

	// Result checker: each strobe is matched against the oldest expectation.
	always @(posedge clk) begin
		res_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$error("result strobe with no command outstanding");
				error_count++;
			end else begin
				want = pending_results.pop_front();
				if (result.given_id !== want.given_id) begin
					$error("given_id: expected %0d, got %0d", want.given_id, result.given_id);
					error_count++;
				end
				if (result.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, result.status);
					error_count++;
				end
			end
		end
	end

	// Sequence of tests.
	initial begin
		int waited;
		error_count = 0;
		full_count  = 0;
		map_active_bytes = 0;
		foreach (id_map[i])
			id_map[i] = 8'h00;
		arst_n <= 1'b0;
		start  <= 1'b0;
		cmd    <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_corners();
		test_mixed_traffic(450, 0);
		test_fill_to_capacity(48);
		test_release_and_reuse(200, 0);
		test_release_and_reuse(200, 38);
		test_mixed_traffic(100, 48);

		// Let the last results come back.
		start <= 1'b0;
		waited = 0;
		while (pending_results.size() > 0 && waited < DRAIN_CYCLES) begin
			@(posedge clk);
			waited++;
		end
		repeat (200) @(posedge clk);
		if (pending_results.size() > 0) begin
			$error("%0d results never arrived", pending_results.size());
			error_count++;
		end

		if (error_count == 0) begin
			$display("bitmap_id_allocator_top: match");
		end else begin
			$display("bitmap_id_allocator_top: mismatch");
		end
		$finish;
	end

	// Watchdog against a hung handshake.
	initial begin
		#40ms;
		$error("timeout waiting on the block");
		$display("bitmap_id_allocator_top: mismatch");
		$finish;
	end

endmodule
